[hw/rtl/tdp_pkg.sv]
// ----------------------------------------------------------------------------
// tdp_pkg: shared types and constants for the time-of-day parser
// Character classes, queue word layout, record layout and limits.
// ----------------------------------------------------------------------------
package tdp_pkg;

    // Widths of the port fields
    localparam int CHAR_WIDTH    = 8;
    localparam int CFG_WIDTH     = 16;
    localparam int SECONDS_WIDTH = 17;
    localparam int FIELD_WIDTH   = 7;
    localparam int DIGIT_WIDTH   = 4;
    localparam int POS_WIDTH     = 4;

    // Width of the record counter
    localparam int COUNT_WIDTH = 16;

    // Compare width for the count check: wide enough for both sides
    localparam int CMP_WIDTH = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
    localparam logic [CMP_WIDTH-1:0] CMP_MASK = CMP_WIDTH'({COUNT_WIDTH{1'b1}});

    // Character codes
    localparam logic [CHAR_WIDTH-1:0] COLON_CHAR = 8'h3A;
    localparam logic [CHAR_WIDTH-1:0] DIGIT_LO   = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] DIGIT_HI   = 8'h39;

    // Record positions
    localparam logic [POS_WIDTH-1:0] POS_FIRST  = 4'd0;
    localparam logic [POS_WIDTH-1:0] POS_COLON1 = 4'd2;
    localparam logic [POS_WIDTH-1:0] POS_COLON2 = 4'd5;
    localparam logic [POS_WIDTH-1:0] POS_TERM   = 4'd8;

    // Range limits and scale factors
    localparam logic [FIELD_WIDTH-1:0] HOURS_LIMIT = 7'd24;
    localparam logic [FIELD_WIDTH-1:0] MIN_LIMIT   = 7'd60;
    localparam int SEC_PER_HOUR = 3600;
    localparam int SEC_PER_MIN  = 60;
    localparam int DIGIT_BASE   = 10;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_WIDTH  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        CLASS_DIGIT,
        CLASS_COLON,
        CLASS_OTHER
    } char_class_t;

    typedef struct packed {
        char_class_t            cls;
        logic [DIGIT_WIDTH-1:0] digit;
    } char_word_t;

    typedef struct packed {
        logic       valid;
        char_word_t word;
    } queue_head_t;

endpackage

[hw/rtl/tdp_front.sv]
// ----------------------------------------------------------------------------
// tdp_front: character intake and classification
// Classifies each accepted character and holds it in a short queue.
// ----------------------------------------------------------------------------
module tdp_front
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            char_valid,
    output logic                            char_stall,
    input  logic [tdp_pkg::CHAR_WIDTH-1:0]  char_in,
    output tdp_pkg::queue_head_t            head,
    input  logic                            pop
);

    tdp_pkg::char_word_t                 slot_reg [tdp_pkg::QUEUE_DEPTH];
    logic [tdp_pkg::QPTR_WIDTH-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [tdp_pkg::QPTR_WIDTH-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [tdp_pkg::QCNT_WIDTH-1:0]      count_reg, count_next;
    tdp_pkg::char_word_t                 word_in;
    logic                                push;
    logic                                do_pop;

    // classify
    always_comb
    begin
        word_in.digit = tdp_pkg::DIGIT_WIDTH'(char_in - tdp_pkg::DIGIT_LO);
        if (char_in >= tdp_pkg::DIGIT_LO && char_in <= tdp_pkg::DIGIT_HI)
        begin
            word_in.cls = tdp_pkg::CLASS_DIGIT;
        end
        else if (char_in == tdp_pkg::COLON_CHAR)
        begin
            word_in.cls = tdp_pkg::CLASS_COLON;
        end
        else
        begin
            word_in.cls = tdp_pkg::CLASS_OTHER;
        end
    end

    assign char_stall = (count_reg == tdp_pkg::QCNT_WIDTH'(tdp_pkg::QUEUE_DEPTH));
    assign push       = char_valid && !char_stall;
    assign do_pop     = pop && (count_reg != '0);

    assign head.valid = (count_reg != '0);
    assign head.word  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == tdp_pkg::QPTR_WIDTH'(tdp_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == tdp_pkg::QPTR_WIDTH'(tdp_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= word_in;
        end
    end

endmodule

[hw/rtl/tdp_back.sv]
// ----------------------------------------------------------------------------
// tdp_back: record parser, range check, running maximum, result register
// Consumes one classified character per cycle unless a result waits on a stalled output, and emits record results.
// ----------------------------------------------------------------------------
module tdp_back
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  tdp_pkg::queue_head_t              head,
    output logic                              pop,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tdp_pkg::CFG_WIDTH-1:0]     cfg_data,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic [tdp_pkg::SECONDS_WIDTH-1:0] record_seconds,
    output logic                              record_valid,
    output logic [tdp_pkg::SECONDS_WIDTH-1:0] max_seconds,
    output logic                              max_present,
    output logic                              format_error,
    output logic                              finished
);

    localparam int TOTAL_WIDTH = tdp_pkg::SECONDS_WIDTH + 2;
    localparam int ACC_WIDTH   = tdp_pkg::FIELD_WIDTH + 4;

    logic [tdp_pkg::CFG_WIDTH-1:0]      record_count_reg;
    logic [tdp_pkg::POS_WIDTH-1:0]      pos_reg, pos_next;
    logic [tdp_pkg::FIELD_WIDTH-1:0]    hours_reg, hours_next;
    logic [tdp_pkg::FIELD_WIDTH-1:0]    minutes_reg, minutes_next;
    logic [tdp_pkg::FIELD_WIDTH-1:0]    acc_reg, acc_next;
    logic [tdp_pkg::COUNT_WIDTH-1:0]    done_reg, done_next;
    logic [tdp_pkg::SECONDS_WIDTH-1:0]  best_reg, best_next;
    logic                               best_present_reg, best_present_next;
    logic                               halted_reg, halted_next;
    logic                               out_valid_reg;

    logic [tdp_pkg::SECONDS_WIDTH-1:0]  secs_reg;
    logic                               rec_valid_reg;
    logic [tdp_pkg::SECONDS_WIDTH-1:0]  max_reg;
    logic                               max_present_reg;
    logic                               err_reg;
    logic                               fin_reg;

    logic [tdp_pkg::CMP_WIDTH-1:0]      limit;
    logic [tdp_pkg::CMP_WIDTH-1:0]      done_ext;
    logic [tdp_pkg::CMP_WIDTH-1:0]      done_inc_ext;
    logic [ACC_WIDTH-1:0]               acc_wide;
    logic [TOTAL_WIDTH-1:0]             total_wide;
    logic [tdp_pkg::SECONDS_WIDTH-1:0]  total;
    logic                               emit;
    logic                               step_secs_valid;
    logic                               step_err;
    logic                               step_fin;
    logic [tdp_pkg::SECONDS_WIDTH-1:0]  step_secs;
    logic                               out_free;

    assign cfg_ready = 1'b1;

    assign limit        = tdp_pkg::CMP_WIDTH'(record_count_reg) & tdp_pkg::CMP_MASK;
    assign done_ext     = tdp_pkg::CMP_WIDTH'(done_reg);
    assign done_inc_ext = tdp_pkg::CMP_WIDTH'(done_reg + 1'b1);

    assign acc_wide = ACC_WIDTH'(acc_reg) * ACC_WIDTH'(tdp_pkg::DIGIT_BASE)
                    + ACC_WIDTH'(head.word.digit);

    assign total_wide = TOTAL_WIDTH'(hours_reg) * TOTAL_WIDTH'(tdp_pkg::SEC_PER_HOUR)
                      + TOTAL_WIDTH'(minutes_reg) * TOTAL_WIDTH'(tdp_pkg::SEC_PER_MIN)
                      + TOTAL_WIDTH'(acc_reg);
    assign total = total_wide[tdp_pkg::SECONDS_WIDTH-1:0];

    always_comb
    begin
        pos_next          = pos_reg;
        hours_next        = hours_reg;
        minutes_next      = minutes_reg;
        acc_next          = acc_reg;
        done_next         = done_reg;
        best_next         = best_reg;
        best_present_next = best_present_reg;
        halted_next       = halted_reg;
        emit              = 1'b0;
        step_secs_valid   = 1'b0;
        step_err          = 1'b0;
        step_fin          = 1'b0;
        step_secs         = '0;

        priority if (halted_reg || done_ext >= limit)
        begin
            // dropped: nothing changes
        end
        else if (pos_reg == tdp_pkg::POS_COLON1 || pos_reg == tdp_pkg::POS_COLON2)
        begin
            if (head.word.cls != tdp_pkg::CLASS_COLON)
            begin
                emit        = 1'b1;
                step_err    = 1'b1;
                step_fin    = 1'b1;
                halted_next = 1'b1;
                pos_next    = tdp_pkg::POS_FIRST;
                acc_next    = '0;
            end
            else
            begin
                if (pos_reg == tdp_pkg::POS_COLON1)
                begin
                    hours_next = acc_reg;
                end
                else
                begin
                    minutes_next = acc_reg;
                end
                acc_next = '0;
                pos_next = pos_reg + 1'b1;
            end
        end
        else if (pos_reg < tdp_pkg::POS_TERM)
        begin
            if (head.word.cls != tdp_pkg::CLASS_DIGIT)
            begin
                emit        = 1'b1;
                step_err    = 1'b1;
                step_fin    = 1'b1;
                halted_next = 1'b1;
                pos_next    = tdp_pkg::POS_FIRST;
                acc_next    = '0;
            end
            else
            begin
                acc_next = acc_wide[tdp_pkg::FIELD_WIDTH-1:0];
                pos_next = pos_reg + 1'b1;
            end
        end
        else
        begin
            // terminator: any byte closes the record
            emit     = 1'b1;
            pos_next = tdp_pkg::POS_FIRST;
            acc_next = '0;
            if (hours_reg >= tdp_pkg::HOURS_LIMIT || minutes_reg >= tdp_pkg::MIN_LIMIT
                || acc_reg >= tdp_pkg::MIN_LIMIT)
            begin
                step_err    = 1'b1;
                step_fin    = 1'b1;
                halted_next = 1'b1;
            end
            else
            begin
                step_secs_valid = 1'b1;
                step_secs       = total;
                if (!best_present_reg || total > best_reg)
                begin
                    best_next         = total;
                    best_present_next = 1'b1;
                end
                done_next = done_reg + 1'b1;
                step_fin  = (done_inc_ext >= limit);
            end
        end
    end

    // a result may go out when the output register is empty or draining
    assign out_free = !out_valid_reg || !result_stall;
    assign pop      = head.valid && (!emit || out_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            record_count_reg <= '0;
            pos_reg          <= '0;
            hours_reg        <= '0;
            minutes_reg      <= '0;
            acc_reg          <= '0;
            done_reg         <= '0;
            best_reg         <= '0;
            best_present_reg <= 1'b0;
            halted_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                record_count_reg <= cfg_data;
            end
            if (pop)
            begin
                pos_reg          <= pos_next;
                hours_reg        <= hours_next;
                minutes_reg      <= minutes_next;
                acc_reg          <= acc_next;
                done_reg         <= done_next;
                best_reg         <= best_next;
                best_present_reg <= best_present_next;
                halted_reg       <= halted_next;
            end
            if (pop && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            secs_reg        <= step_secs;
            rec_valid_reg   <= step_secs_valid;
            max_reg         <= best_next;
            max_present_reg <= best_present_next;
            err_reg         <= step_err;
            fin_reg         <= step_fin;
        end
    end

    assign result_valid   = out_valid_reg;
    assign record_seconds = secs_reg;
    assign record_valid   = rec_valid_reg;
    assign max_seconds    = max_reg;
    assign max_present    = max_present_reg;
    assign format_error   = err_reg;
    assign finished       = fin_reg;

endmodule

[hw/rtl/time_of_day_parse_max.sv]
// ----------------------------------------------------------------------------
// time_of_day_parse_max: HH:MM:SS record parser with running maximum
// Parses a character stream into seconds of day, keeps the maximum, and
// reports one result word per record, halting on the first bad record.
// ----------------------------------------------------------------------------
//
//  channel   handshake              word
//  -------   --------------------   ---------------------------------------
//  char      char_valid/char_stall  char_in
//  cfg       cfg_valid/cfg_ready    cfg_data (record_count)
//  result    result_valid/          record_seconds, record_valid,
//            result_stall           max_seconds, max_present,
//                                   format_error, finished
//
//  One character per cycle sustained while result_stall stays low; a record of
//  nine characters gives its result word once its terminator has passed the
//  front queue and then the back-end output register.
//  Reset clears parser state, counter, maximum and record_count; no
//  clearing pass.
//  A stalled result holds in the output register; the two-word queue keeps
//  taking characters until it fills, then char_stall rises.
//  cfg_ready is always high.
//
module time_of_day_parse_max
(
    input  logic                              clk,
    input  logic                              rst_n,

    // character input
    input  logic                              char_valid,
    output logic                              char_stall,
    input  logic [tdp_pkg::CHAR_WIDTH-1:0]    char_in,

    // configuration
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tdp_pkg::CFG_WIDTH-1:0]     cfg_data,

    // results
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic [tdp_pkg::SECONDS_WIDTH-1:0] record_seconds,
    output logic                              record_valid,
    output logic [tdp_pkg::SECONDS_WIDTH-1:0] max_seconds,
    output logic                              max_present,
    output logic                              format_error,
    output logic                              finished
);

    tdp_pkg::queue_head_t head;
    logic                 pop;

    // Front: classify each character (digit, colon, other) into a queue
    tdp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_in    (char_in),
        .head       (head),
        .pop        (pop)
    );

    // Back: position-driven parse, range check, max tracking, result register
    tdp_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .pop            (pop),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .record_seconds (record_seconds),
        .record_valid   (record_valid),
        .max_seconds    (max_seconds),
        .max_present    (max_present),
        .format_error   (format_error),
        .finished       (finished)
    );

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the time-of-day parser
// Streams HH:MM:SS records one character at a time under several idling
// mixes, predicts every result word in a scoreboard and compares each field.
// ----------------------------------------------------------------------------
module tb_top;

    import tdp_pkg::*;

    // Run control
    localparam int unsigned CYCLE_LIMIT  = 400000;  // far above the slowest run
    localparam int unsigned TAIL_CYCLES  = 10;      // tail after the last expected word
    localparam int unsigned RECORD_CHARS = 1800;    // record characters in the random part

    // One result word as the block presents it
    typedef struct packed {
        logic [SECONDS_WIDTH-1:0] secs;
        logic                     rec_ok;
        logic [SECONDS_WIDTH-1:0] best;
        logic                     best_ok;
        logic                     err;
        logic                     fin;
    } tod_result_t;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_e;

    typedef enum int {
        BAD_DIGIT,
        BAD_COLON,
        HOURS_HIGH,
        MINUTES_HIGH,
        SECONDS_HIGH
    } bad_kind_e;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks the parser state, queues the words it must emit and
    // checks each accepted word against the oldest one.
    // ------------------------------------------------------------------------
    class record_max_board;
        logic [CFG_WIDTH-1:0]     count_limit;
        logic [POS_WIDTH-1:0]     pos;
        logic [FIELD_WIDTH-1:0]   hrs;
        logic [FIELD_WIDTH-1:0]   mins;
        logic [FIELD_WIDTH-1:0]   acc;
        logic [COUNT_WIDTH-1:0]   done;
        logic [SECONDS_WIDTH-1:0] best;
        logic                     has_best;
        logic                     stopped;
        tod_result_t              pending_results[$];
        int unsigned              mismatches;

        function new();
            count_limit = '0;
            pos         = '0;
            hrs         = '0;
            mins        = '0;
            acc         = '0;
            done        = '0;
            best        = '0;
            has_best    = 1'b0;
            stopped     = 1'b0;
            mismatches  = 0;
        endfunction

        function void set_count(logic [CFG_WIDTH-1:0] value);
            count_limit = value;
        endfunction

        // count is masked to the counter width before the compare
        function bit count_reached();
            return CMP_WIDTH'(done) >= (CMP_WIDTH'(count_limit) & CMP_MASK);
        endfunction

        function void push_result(logic [SECONDS_WIDTH-1:0] secs, logic ok,
                                  logic err, logic fin);
            tod_result_t word;
            word.secs    = secs;
            word.rec_ok  = ok;
            word.best    = has_best ? best : '0;
            word.best_ok = has_best;
            word.err     = err;
            word.fin     = fin;
            pending_results.push_back(word);
        endfunction

        function void halt_on_error();
            stopped = 1'b1;
            pos     = '0;
            acc     = '0;
            push_result('0, 1'b0, 1'b1, 1'b1);
        endfunction

        function void parse_char(logic [CHAR_WIDTH-1:0] c);
            int unsigned total;
            if (stopped || count_reached())
                return;
            if (pos == POS_COLON1 || pos == POS_COLON2)
            begin
                if (c != COLON_CHAR)
                begin
                    halt_on_error();
                    return;
                end
                if (pos == POS_COLON1)
                    hrs = acc;
                else
                    mins = acc;
                acc = '0;
                pos = pos + 1'b1;
                return;
            end
            if (pos < POS_TERM)
            begin
                if (c < DIGIT_LO || c > DIGIT_HI)
                begin
                    halt_on_error();
                    return;
                end
                acc = FIELD_WIDTH'(acc * DIGIT_BASE + (c - DIGIT_LO));
                pos = pos + 1'b1;
                return;
            end
            // terminator: any byte closes the record, range check here
            if (hrs >= HOURS_LIMIT || mins >= MIN_LIMIT || acc >= MIN_LIMIT)
            begin
                halt_on_error();
                return;
            end
            total = hrs * SEC_PER_HOUR + mins * SEC_PER_MIN + acc;
            if (!has_best || total > best)
            begin
                best     = SECONDS_WIDTH'(total);
                has_best = 1'b1;
            end
            done = done + 1'b1;
            pos  = '0;
            acc  = '0;
            push_result(SECONDS_WIDTH'(total), 1'b1, 1'b0, count_reached());
        endfunction

        task note_mismatch(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            mismatches++;
        endtask

        task compare_field(string name, logic [SECONDS_WIDTH-1:0] got,
                           logic [SECONDS_WIDTH-1:0] want);
            if (got !== want)
                note_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        endtask

        task check_word(tod_result_t got);
            tod_result_t want;
            if (pending_results.size() == 0)
            begin
                note_mismatch($sformatf("unexpected word, record_seconds %0d", got.secs));
                return;
            end
            want = pending_results.pop_front();
            compare_field("record_seconds", got.secs, want.secs);
            compare_field("record_valid", got.rec_ok, want.rec_ok);
            compare_field("max_seconds", got.best, want.best);
            compare_field("max_present", got.best_ok, want.best_ok);
            compare_field("format_error", got.err, want.err);
            compare_field("finished", got.fin, want.fin);
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                     char_valid;
    logic                     char_stall;
    logic [CHAR_WIDTH-1:0]    char_in;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_WIDTH-1:0]     cfg_data;
    logic                     result_valid;
    logic                     result_stall = 1'b0;
    logic [SECONDS_WIDTH-1:0] record_seconds;
    logic                     record_valid;
    logic [SECONDS_WIDTH-1:0] max_seconds;
    logic                     max_present;
    logic                     format_error;
    logic                     finished;

    record_max_board board;
    int unsigned     gap_pct   = 0;     // chance per cycle that the sender idles
    int unsigned     stall_pct = 0;     // chance per cycle that the receiver stalls
    int unsigned     cycles    = 0;
    int unsigned     record_chars = 0;  // characters sent inside records

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    time_of_day_parse_max u_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .char_valid     (char_valid),
        .char_stall     (char_stall),
        .char_in        (char_in),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .record_seconds (record_seconds),
        .record_valid   (record_valid),
        .max_seconds    (max_seconds),
        .max_present    (max_present),
        .format_error   (format_error),
        .finished       (finished)
    );

    // Watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver back-pressure, redrawn every cycle at the falling edge
    always @(negedge clk)
        result_stall <= ($urandom_range(99) < stall_pct);

    // Monitor: everything is sampled at the rising edge. Config, characters
    // and results never interact within one edge (a result passes queue and output register).
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                board.set_count(cfg_data);
            if (char_valid && !char_stall)
                board.parse_char(char_in);
            if (result_valid && !result_stall)
                board.check_word(tod_result_t'{record_seconds, record_valid,
                                               max_seconds, max_present,
                                               format_error, finished});
        end
    end

    // ------------------------------------------------------------------------
    // Drivers. All of them are entered and left at a falling edge.
    // ------------------------------------------------------------------------

    // One character word. char_valid stays high on exit so back-to-back words
    // need only one assignment per step; quiesce() drops it.
    task send_char(logic [CHAR_WIDTH-1:0] c);
        while ($urandom_range(99) < gap_pct)
        begin
            char_valid <= 1'b0;
            @(negedge clk);
        end
        char_valid <= 1'b1;
        char_in    <= c;
        do
            @(posedge clk);
        while (char_stall !== 1'b0);
        @(negedge clk);
    endtask

    task quiesce();
        char_valid <= 1'b0;
        while (board.pending_results.size() != 0)
            @(negedge clk);
        // a trailing ignored character may still be in the pipe
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    // Only called with the block idle (after quiesce)
    task write_record_count(logic [CFG_WIDTH-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task set_idling(idle_mode_e mode);
        case (mode)
            IDLE_SENDER:   begin gap_pct = 46; stall_pct = 0;  end
            IDLE_RECEIVER: begin gap_pct = 0;  stall_pct = 46; end
            IDLE_BOTH:     begin gap_pct = 30; stall_pct = 30; end
            default:       begin gap_pct = 0;  stall_pct = 0;  end
        endcase
    endtask

    // HH:MM:SS plus terminator as nine bytes
    function automatic void time_chars(int unsigned h, int unsigned m, int unsigned s,
                                       logic [CHAR_WIDTH-1:0] term,
                                       output logic [CHAR_WIDTH-1:0] rec[9]);
        rec[0] = CHAR_WIDTH'(DIGIT_LO + h / 10);
        rec[1] = CHAR_WIDTH'(DIGIT_LO + h % 10);
        rec[2] = COLON_CHAR;
        rec[3] = CHAR_WIDTH'(DIGIT_LO + m / 10);
        rec[4] = CHAR_WIDTH'(DIGIT_LO + m % 10);
        rec[5] = COLON_CHAR;
        rec[6] = CHAR_WIDTH'(DIGIT_LO + s / 10);
        rec[7] = CHAR_WIDTH'(DIGIT_LO + s % 10);
        rec[8] = term;
    endfunction

    task send_time(int unsigned h, int unsigned m, int unsigned s,
                   logic [CHAR_WIDTH-1:0] term);
        logic [CHAR_WIDTH-1:0] rec[9];
        time_chars(h, m, s, term, rec);
        foreach (rec[i])
            send_char(rec[i]);
        record_chars += 9;
    endtask

    // Mostly uniform times; now and then the two ends of the day
    task send_random_time();
        logic [CHAR_WIDTH-1:0] term;
        term = CHAR_WIDTH'($urandom_range(255));
        case ($urandom_range(15))
            0:       send_time(23, 59, 59, term);
            1:       send_time(0, 0, 0, term);
            default: send_time($urandom_range(23), $urandom_range(59),
                               $urandom_range(59), term);
        endcase
    endtask

    // Characters the block must drop (count reached, zero count, or halted)
    task send_ignored(int unsigned n);
        repeat (n) send_char(CHAR_WIDTH'($urandom_range(255)));
    endtask

    // The single error the run can afford: the block stays halted until reset
    task send_bad_record();
        logic [CHAR_WIDTH-1:0] rec[9];
        logic [CHAR_WIDTH-1:0] c;
        int unsigned           h;
        int unsigned           m;
        int unsigned           s;
        int unsigned           last;
        int unsigned           digit_pos[6];
        bad_kind_e             kind;
        digit_pos = '{0, 1, 3, 4, 6, 7};
        kind = bad_kind_e'($urandom_range(SECONDS_HIGH));
        h = $urandom_range(23);
        m = $urandom_range(59);
        s = $urandom_range(59);
        case (kind)
            HOURS_HIGH:   h = $urandom_range(99, 24);
            MINUTES_HIGH: m = $urandom_range(99, 60);
            SECONDS_HIGH: s = $urandom_range(99, 60);
            default:      ;
        endcase
        time_chars(h, m, s, CHAR_WIDTH'($urandom_range(255)), rec);
        last = POS_TERM;
        if (kind == BAD_DIGIT)
        begin
            last = digit_pos[$urandom_range(5)];
            do
                c = CHAR_WIDTH'($urandom_range(255));
            while (c >= DIGIT_LO && c <= DIGIT_HI);
            rec[last] = c;
        end
        else if (kind == BAD_COLON)
        begin
            last = $urandom_range(1) ? POS_COLON2 : POS_COLON1;
            do
                c = CHAR_WIDTH'($urandom_range(255));
            while (c == COLON_CHAR);
            rec[last] = c;
        end
        // bad character errors at once; range errors wait for the terminator
        for (int unsigned i = 0; i <= last; i++)
            send_char(rec[i]);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        idle_mode_e  schedule[5];
        int unsigned phase;
        int unsigned sent;
        int unsigned pause_at;

        schedule = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH, IDLE_NONE};
        board = new();
        char_valid <= 1'b0;
        char_in    <= '0;
        cfg_valid  <= 1'b0;
        cfg_data   <= '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Count resets to zero: the parser must drop everything
        send_ignored(4);
        quiesce();
        write_record_count('0);
        send_ignored(4);
        quiesce();

        // Directed: day start, day end (max holds after it), digit terminator;
        // the third record hits the count and carries finished.
        write_record_count(16'd3);
        send_time(0, 0, 0, 8'h00);
        send_time(23, 59, 59, 8'hFF);
        send_time(12, 34, 56, CHAR_WIDTH'(DIGIT_LO + 7));
        send_ignored(2);
        quiesce();

        // Random phases: each one raises the count by a few records, runs to
        // finished, then throws a few bytes at the stopped parser.
        phase = 0;
        while (record_chars < RECORD_CHARS)
        begin
            set_idling(schedule[phase % 5]);
            write_record_count(CFG_WIDTH'(board.done + $urandom_range(30, 1)));
            pause_at = (phase == 0) ? 1 : $urandom_range(12);
            sent = 0;
            while (!board.count_reached())
            begin
                send_random_time();
                sent++;
                // sender holds off until every word is out; sometimes the
                // count is raised mid-run while the parser is between records
                if (sent == pause_at)
                begin
                    quiesce();
                    if ($urandom_range(1))
                        write_record_count(CFG_WIDTH'(board.count_limit +
                                                      $urandom_range(4, 1)));
                end
            end
            send_ignored($urandom_range(4, 1));
            quiesce();
            phase++;
        end

        // Widest count, a few more records, then the error that halts it all
        set_idling(schedule[phase % 5]);
        write_record_count('1);
        repeat ($urandom_range(10, 3)) send_random_time();
        send_bad_record();
        send_ignored(6);
        quiesce();

        if (board.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
